// ===== sv/rtp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtp_pkg;

	// Packet size at which the byte counter stops counting
	localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;

	localparam logic [15:0] FIXED_HDR_BYTES = 16'd12;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_VERSION  = 3'd2;
	localparam logic [2:0] ST_PADDING  = 3'd3;
	localparam logic [2:0] ST_CSRC     = 3'd4;
	localparam logic [2:0] ST_EXT_HDR  = 3'd5;
	localparam logic [2:0] ST_EXT_BODY = 3'd6;

	localparam logic [1:0] RTP_VERSION = 2'd2;

	// Header as seen with the current byte already captured
	typedef struct packed {
		logic [15:0] len;
		logic [7:0]  hdr0;
		logic [7:0]  hdr1;
		logic [15:0] seq;
		logic [31:0] stamp;
		logic [31:0] ssrc;
		logic [15:0] ext_words;
		logic [7:0]  last_data;
	} rtp_hdr_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        marker;
		logic [6:0]  payload_type;
		logic [15:0] sequence_number;
		logic [31:0] time_stamp;
		logic [31:0] sync_source;
		logic [3:0]  csrc_count;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} rtp_result_t;

endpackage

`default_nettype wire

// ===== sv/rtp_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rtp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/rtp_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rtp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        marker;
	logic [6:0]  payload_type;
	logic [15:0] sequence_number;
	logic [31:0] time_stamp;
	logic [31:0] sync_source;
	logic [3:0]  csrc_count;
	logic [15:0] payload_offset;
	logic [15:0] payload_length;

	modport source (
		output valid, output status, output marker, output payload_type,
		output sequence_number, output time_stamp, output sync_source,
		output csrc_count, output payload_offset, output payload_length,
		input ready
	);
	modport sink (
		input valid, input status, input marker, input payload_type,
		input sequence_number, input time_stamp, input sync_source,
		input csrc_count, input payload_offset, input payload_length,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/rtp_capture.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtp_capture
	import rtp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] data,
	input  wire logic       last,
	output rtp_hdr_t        hdr
);

	logic [15:0] cnt_q, cnt_n;
	logic [7:0]  hdr0_q, hdr0_n;
	logic [7:0]  hdr1_q, hdr1_n;
	logic [15:0] seq_q, seq_n;
	logic [31:0] stamp_q, stamp_n;
	logic [31:0] ssrc_q, ssrc_n;
	logic [15:0] ext_q, ext_n;
	logic [15:0] ext_pos;

	// Extension length word sits right after the CSRC list plus the profile word
	assign ext_pos = 16'd14 + {10'd0, hdr0_q[3:0], 2'b00};

	always_comb begin
		hdr0_n  = hdr0_q;
		hdr1_n  = hdr1_q;
		seq_n   = seq_q;
		stamp_n = stamp_q;
		ssrc_n  = ssrc_q;
		ext_n   = ext_q;
		if (cnt_q == 16'd0) begin
			hdr0_n = data;
		end else if (cnt_q == 16'd1) begin
			hdr1_n = data;
		end else if (cnt_q <= 16'd3) begin
			seq_n = {seq_q[7:0], data};
		end else if (cnt_q <= 16'd7) begin
			stamp_n = {stamp_q[23:0], data};
		end else if (cnt_q <= 16'd11) begin
			ssrc_n = {ssrc_q[23:0], data};
		end
		if (cnt_q == ext_pos || cnt_q == ext_pos + 16'd1) begin
			ext_n = {ext_q[7:0], data};
		end
		cnt_n = (cnt_q >= MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : cnt_q + 16'd1;
	end

	assign hdr = '{
		len:       cnt_n,
		hdr0:      hdr0_n,
		hdr1:      hdr1_n,
		seq:       seq_n,
		stamp:     stamp_n,
		ssrc:      ssrc_n,
		ext_words: ext_n,
		last_data: data
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			hdr0_q  <= '0;
			hdr1_q  <= '0;
			seq_q   <= '0;
			stamp_q <= '0;
			ssrc_q  <= '0;
			ext_q   <= '0;
		end else if (advance) begin
			if (last) begin
				cnt_q   <= '0;
				hdr0_q  <= '0;
				hdr1_q  <= '0;
				seq_q   <= '0;
				stamp_q <= '0;
				ssrc_q  <= '0;
				ext_q   <= '0;
			end else begin
				cnt_q   <= cnt_n;
				hdr0_q  <= hdr0_n;
				hdr1_q  <= hdr1_n;
				seq_q   <= seq_n;
				stamp_q <= stamp_n;
				ssrc_q  <= ssrc_n;
				ext_q   <= ext_n;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/rtp_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rtp_check
	import rtp_pkg::*;
(
	input  wire rtp_hdr_t hdr,
	output rtp_result_t   res
);

	logic        pad_on, ext_on, pad_bad;
	logic [15:0] newsize;
	logic [15:0] base_off;
	logic [16:0] ext_hdr_end;
	logic [18:0] body_end;
	logic [2:0]  status;
	logic [15:0] offset;

	assign pad_on  = hdr.hdr0[5];
	assign ext_on  = hdr.hdr0[4];
	assign pad_bad = pad_on &&
		(({9'd0, hdr.last_data} + 17'd12) > {1'b0, hdr.len});
	assign newsize = pad_on ? hdr.len - {8'd0, hdr.last_data} : hdr.len;

	assign base_off    = FIXED_HDR_BYTES + {10'd0, hdr.hdr0[3:0], 2'b00};
	assign ext_hdr_end = {1'b0, base_off} + 17'd4;
	assign body_end    = {2'b00, ext_hdr_end} + {1'b0, hdr.ext_words, 2'b00};

	always_comb begin
		status = ST_OK;
		offset = base_off;
		priority if (hdr.len < FIXED_HDR_BYTES) begin
			status = ST_SHORT;
		end else if (hdr.hdr0[7:6] != RTP_VERSION) begin
			status = ST_VERSION;
		end else if (pad_bad) begin
			status = ST_PADDING;
		end else if (newsize < base_off) begin
			status = ST_CSRC;
		end else if (ext_on && ({1'b0, newsize} < ext_hdr_end)) begin
			status = ST_EXT_HDR;
		end else if (ext_on && ({3'b000, newsize} < body_end)) begin
			status = ST_EXT_BODY;
		end else if (ext_on) begin
			offset = body_end[15:0];
		end else begin
			offset = base_off;
		end
	end

	always_comb begin
		res = '0;
		res.status = status;
		if (status == ST_OK) begin
			res.marker          = hdr.hdr1[7];
			res.payload_type    = hdr.hdr1[6:0];
			res.sequence_number = hdr.seq;
			res.time_stamp      = hdr.stamp;
			res.sync_source     = hdr.ssrc;
			res.csrc_count      = hdr.hdr0[3:0];
			res.payload_offset  = offset;
			res.payload_length  = newsize - offset;
		end
	end

endmodule

`default_nettype wire

// ===== sv/rtp_header_parser.sv =====
// The last byte passes through the input register (s1) and then the result
// register; the result transaction can happen once the result register holds it.
// Throughput: one byte per cycle outside the stall below; the single-pass check
// logic between the input register and the result register sets this figure.
// Input stalls only while a last byte waits behind an untaken result.
// Reset (arst_n, async, active low) empties both registers and clears header state.
`timescale 1ns / 1ps
`default_nettype none

module rtp_header_parser
	import rtp_pkg::*;
(
	input wire logic   clk,
	input wire logic   arst_n,
	rtp_byte_if.sink   pkt,
	rtp_result_if.source res
);

	// Input register stage
	logic       s1_valid_q;
	logic [7:0] s1_data_q;
	logic       s1_last_q;

	// Result register
	logic        out_valid_q;
	rtp_result_t out_q;

	logic        s1_go;
	logic        out_load;
	rtp_hdr_t    hdr;
	rtp_result_t chk;

	// A byte in s1 moves on unless it is a last byte and the result slot is
	// still held by an untaken transaction.
	assign s1_go    = s1_valid_q && !(s1_last_q && out_valid_q && !res.ready);
	assign out_load = s1_go && s1_last_q;
	assign pkt.ready = !s1_valid_q || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pkt.ready) begin
			s1_valid_q <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			s1_data_q <= pkt.data_byte;
			s1_last_q <= pkt.last_byte;
		end
	end

	// Byte counter and header capture; hdr shows the state with s1's byte applied
	rtp_capture u_capture (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (s1_go),
		.data    (s1_data_q),
		.last    (s1_last_q),
		.hdr     (hdr)
	);

	// Status and payload bounds for a packet ending at s1's byte
	rtp_check u_check (
		.hdr (hdr),
		.res (chk)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= chk;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.status          = out_q.status;
	assign res.marker          = out_q.marker;
	assign res.payload_type    = out_q.payload_type;
	assign res.sequence_number = out_q.sequence_number;
	assign res.time_stamp      = out_q.time_stamp;
	assign res.sync_source     = out_q.sync_source;
	assign res.csrc_count      = out_q.csrc_count;
	assign res.payload_offset  = out_q.payload_offset;
	assign res.payload_length  = out_q.payload_length;

	// A last byte leaving s1 always produces a result
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> res.valid)
		else $error("last byte left s1 without a result");

	// Error results carry zero bounds
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != ST_OK) |->
			(res.payload_offset == 16'd0 && res.payload_length == 16'd0))
		else $error("error result with nonzero payload bounds");

	// Status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.status <= ST_EXT_BODY))
		else $error("undefined status code");

	// Input only stalls behind a pending last byte and a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt.ready |-> (s1_valid_q && s1_last_q && out_valid_q))
		else $error("input stalled without cause");

endmodule

`default_nettype wire

// ===== tb/rtp_header_parser_tb.sv =====
`timescale 1ns / 1ps

// Packet-level testbench for the RTP fixed-header parser.
// Bytes go in through the pkt channel and one verdict per packet comes back
// on the res channel. The scoreboard predicts each verdict byte by byte.
module rtp_header_parser_tb;
	import rtp_pkg::*;

	// Cycles with no transaction on either channel before the run is abandoned.
	// Longest legal quiet stretch is the receiver hold-off plus a long gap.
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned RANDOM_BYTES = 200;
	localparam int unsigned RANDOM_PACKETS = 6;
	// Slack after the last expected verdict has been taken.
	localparam int unsigned DRAIN_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n;

	rtp_byte_if pkt_bus ();
	rtp_result_if res_bus ();

	rtp_header_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_bus),
		.res    (res_bus)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Scoreboard state: our own copy of the header capture registers
	// ------------------------------------------------------------------
	logic [15:0] rx_count;      // bytes seen so far in the current packet
	logic [7:0]  hdr_byte0;     // V/P/X/CC
	logic [7:0]  hdr_byte1;     // M/PT
	logic [15:0] seq_shadow;
	logic [31:0] stamp_shadow;
	logic [31:0] ssrc_shadow;
	logic [15:0] ext_len_shadow; // extension length word, in 32-bit words

	rtp_result_t expected_verdicts[$];
	int unsigned fail_count = 0;

	// Stimulus knobs
	logic [7:0]  packet_bytes[$];   // packet being assembled by a test
	bit          tx_steady = 1'b0;  // sender offers back to back
	bit          rx_steady = 1'b0;  // receiver always ready
	int unsigned hold_left = 0;     // receiver hold-off request, counted down by receiver

	function automatic void clear_header_shadow();
		rx_count = '0;
		hdr_byte0 = '0;
		hdr_byte1 = '0;
		seq_shadow = '0;
		stamp_shadow = '0;
		ssrc_shadow = '0;
		ext_len_shadow = '0;
	endfunction

	// Advance the header shadow by one accepted byte; on the last byte,
	// queue the verdict the parser should produce.
	function automatic void parse_byte(input logic [7:0] b, input logic is_last);
		int unsigned idx;
		int unsigned ext_pos;
		int unsigned pkt_len;
		int unsigned room;
		int unsigned offset;
		logic [2:0]  st;
		rtp_result_t verdict;

		idx = rx_count;
		// Extension length word sits right after the 2-byte profile field
		ext_pos = FIXED_HDR_BYTES + 4 * 32'(hdr_byte0[3:0]) + 2;

		if (idx == 0) begin
			hdr_byte0 = b;
		end else if (idx == 1) begin
			hdr_byte1 = b;
		end else if (idx <= 3) begin
			seq_shadow = {seq_shadow[7:0], b};
		end else if (idx <= 7) begin
			stamp_shadow = {stamp_shadow[23:0], b};
		end else if (idx <= 11) begin
			ssrc_shadow = {ssrc_shadow[23:0], b};
		end
		if (idx == ext_pos || idx == ext_pos + 1) begin
			ext_len_shadow = {ext_len_shadow[7:0], b};
		end

		// Counter sticks at the max packet size
		rx_count = (idx >= 32'(MAX_PACKET_BYTES)) ? MAX_PACKET_BYTES : 16'(idx + 1);

		if (!is_last) begin
			return;
		end

		pkt_len = rx_count;
		room = pkt_len;
		offset = 0;
		st = ST_OK;

		if (pkt_len < 32'(FIXED_HDR_BYTES)) begin
			st = ST_SHORT;
		end else if (hdr_byte0[7:6] != RTP_VERSION) begin
			st = ST_VERSION;
		end else begin
			// P bit: final byte holds the pad count, must fit after the fixed header
			if (hdr_byte0[5]) begin
				if (32'(b) + 32'(FIXED_HDR_BYTES) > room) begin
					st = ST_PADDING;
				end else begin
					room = room - 32'(b);
				end
			end
			if (st == ST_OK) begin
				offset = 32'(FIXED_HDR_BYTES) + 4 * 32'(hdr_byte0[3:0]);
				if (room < offset) begin
					st = ST_CSRC;
				end else if (hdr_byte0[4]) begin
					if (room < offset + 4) begin
						st = ST_EXT_HDR;
					end else if (room < offset + 4 + 4 * 32'(ext_len_shadow)) begin
						st = ST_EXT_BODY;
					end else begin
						offset = offset + 4 + 4 * 32'(ext_len_shadow);
					end
				end
			end
		end

		// Any error zeroes every field but the status
		verdict = '0;
		verdict.status = st;
		if (st == ST_OK) begin
			verdict.marker = hdr_byte1[7];
			verdict.payload_type = hdr_byte1[6:0];
			verdict.sequence_number = seq_shadow;
			verdict.time_stamp = stamp_shadow;
			verdict.sync_source = ssrc_shadow;
			verdict.csrc_count = hdr_byte0[3:0];
			verdict.payload_offset = 16'(offset);
			verdict.payload_length = 16'(room - offset);
		end
		expected_verdicts.insert(expected_verdicts.size(), verdict);

		clear_header_shadow();
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Mostly no gap, sometimes a few cycles, rarely a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(8, 40);
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: ready driver and checker
	// ------------------------------------------------------------------

	// Receiver ready, updated once per falling edge. A hold-off request
	// takes priority and is counted down here.
	initial begin
		int unsigned gap_left;
		gap_left = 0;
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_bus.ready = 1'b0;
				hold_left--;
			end else if (gap_left > 0) begin
				res_bus.ready = 1'b0;
				gap_left--;
			end else if (rx_steady) begin
				res_bus.ready = 1'b1;
			end else begin
				gap_left = pick_gap();
				if (gap_left == 0) begin
					res_bus.ready = 1'b1;
				end else begin
					res_bus.ready = 1'b0;
					gap_left--;
				end
			end
		end
	end

	// Compare every accepted verdict against the oldest prediction
	always @(posedge clk) begin
		rtp_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result transaction, status %0d", res_bus.status);
				fail_count++;
			end else begin
				want = expected_verdicts.pop_front();
				check_field("status", 32'(want.status), 32'(res_bus.status));
				check_field("marker", 32'(want.marker), 32'(res_bus.marker));
				check_field("payload_type", 32'(want.payload_type), 32'(res_bus.payload_type));
				check_field("sequence_number", 32'(want.sequence_number),
					32'(res_bus.sequence_number));
				check_field("time_stamp", want.time_stamp, res_bus.time_stamp);
				check_field("sync_source", want.sync_source, res_bus.sync_source);
				check_field("csrc_count", 32'(want.csrc_count), 32'(res_bus.csrc_count));
				check_field("payload_offset", 32'(want.payload_offset),
					32'(res_bus.payload_offset));
				check_field("payload_length", 32'(want.payload_length),
					32'(res_bus.payload_length));
			end
		end
	end

	// Watchdog: a long run with no transaction anywhere means a hang
	always @(posedge clk) begin
		int unsigned quiet_cycles;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((pkt_bus.valid && pkt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$error("no transaction for %0d cycles, %0d verdicts outstanding",
					quiet_cycles, expected_verdicts.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Byte side: sender and packet builders
	// ------------------------------------------------------------------

	// Entered just after a falling edge; returns just after a falling edge.
	// valid stays high between back-to-back bytes.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int unsigned gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			pkt_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pkt_bus.valid = 1'b1;
		pkt_bus.data_byte = b;
		pkt_bus.last_byte = is_last;
		do begin
			@(posedge clk);
		end while (!pkt_bus.ready);
		parse_byte(b, is_last);
		@(negedge clk);
	endtask

	task automatic send_packet();
		foreach (packet_bytes[i]) begin
			send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
		end
	endtask

	task automatic push_byte(input logic [7:0] b);
		packet_bytes.insert(packet_bytes.size(), b);
	endtask

	task automatic push_random(input int unsigned n);
		repeat (n) push_byte(8'($urandom));
	endtask

	task automatic start_header(input logic [7:0] b0, input logic [7:0] b1,
		input logic [15:0] seq, input logic [31:0] stamp, input logic [31:0] ssrc);
		packet_bytes.delete();
		push_byte(b0);
		push_byte(b1);
		push_byte(seq[15:8]);
		push_byte(seq[7:0]);
		for (int i = 3; i >= 0; i--) push_byte(stamp[8*i +: 8]);
		for (int i = 3; i >= 0; i--) push_byte(ssrc[8*i +: 8]);
	endtask

	task automatic start_random_header(input logic [7:0] b0);
		start_header(b0, 8'($urandom), 16'($urandom), $urandom, $urandom);
	endtask

	// Mostly well-formed packets with random content; the rest are truncated,
	// wrong-version or plain garbage.
	task automatic build_random_packet();
		int unsigned kind;
		int unsigned cc;
		int unsigned ext_n;
		int unsigned pad;
		int unsigned keep;
		logic [1:0]  ver;
		logic        has_pad;
		logic        has_ext;

		kind = $urandom_range(0, 99);
		if (kind >= 88) begin
			packet_bytes.delete();
			push_random($urandom_range(1, 30));
			return;
		end
		ver = (kind >= 80) ? 2'($urandom_range(0, 3)) : RTP_VERSION;
		has_pad = ($urandom_range(0, 3) == 0);
		has_ext = ($urandom_range(0, 2) == 0);
		cc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
		// Occasionally a huge extension length to hit the short-body case
		ext_n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);

		start_random_header({ver, has_pad, has_ext, 4'(cc)});
		push_random(4 * cc);
		if (has_ext) begin
			push_random(2);
			push_byte(ext_n[15:8]);
			push_byte(ext_n[7:0]);
			push_random(4 * ((ext_n <= 3) ? ext_n : $urandom_range(0, 3)));
		end
		push_random($urandom_range(0, 24));
		if (has_pad) begin
			// Usually an honest pad count, sometimes anything
			pad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6);
			if (pad >= 1 && pad <= 6) begin
				push_random(pad - 1);
			end
			push_byte(8'(pad));
		end
		if (kind >= 70 && kind < 80) begin
			keep = $urandom_range(1, packet_bytes.size());
			while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Under 12 bytes: 1-byte packet and 11-byte packet
	task automatic test_short_packets();
		packet_bytes.delete();
		push_byte(8'h80);
		send_packet();
		packet_bytes.delete();
		push_random(11);
		packet_bytes[0] = 8'h80;
		send_packet();
	endtask

	// Versions 0, 1, 3 with every other header bit set
	task automatic test_bad_version();
		logic [1:0] bad_versions[3] = '{2'd0, 2'd1, 2'd3};
		foreach (bad_versions[i]) begin
			start_random_header({bad_versions[i], 6'h3F});
			push_random(20);
			send_packet();
		end
	endtask

	// Header-only packet with all-ones fields, then all-zeros fields and a short payload
	task automatic test_header_extremes();
		start_header(8'h80, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_packet();
		start_header(8'h80, 8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000);
		push_random(5);
		send_packet();
	endtask

	// Pad count exactly fills, overflows by one, zero, and maximum
	task automatic test_padding();
		start_random_header(8'hA0);
		push_random(7);
		push_byte(8'd8);
		send_packet();
		start_random_header(8'hA0);
		push_random(7);
		push_byte(8'd9);
		send_packet();
		start_random_header(8'hA0);
		push_random(7);
		push_byte(8'd0);
		send_packet();
		start_random_header(8'hA0);
		push_random(254);
		push_byte(8'd255);
		send_packet();
	endtask

	// Full CSRC list: one byte short, exact, and short once padding comes off
	task automatic test_csrc_list();
		start_random_header(8'h8F);
		push_random(59);
		send_packet();
		start_random_header(8'h8F);
		push_random(60);
		send_packet();
		start_random_header(8'hAF);
		push_random(59);
		push_byte(8'd1);
		send_packet();
	endtask

	// Extension: header cut short, body cut short, body with payload after it, huge length word
	task automatic test_extension();
		start_random_header(8'h91);
		push_random(4 + 3);
		send_packet();

		start_random_header(8'h91);
		push_random(4 + 2);
		push_byte(8'h00);
		push_byte(8'h02);
		push_random(7);
		send_packet();

		start_random_header(8'h91);
		push_random(4 + 2);
		push_byte(8'h00);
		push_byte(8'h02);
		push_random(8 + 5);
		send_packet();

		start_random_header(8'h90);
		push_random(2);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_random(24);
		send_packet();
	endtask

	// Largest header layout: full CSRC list, a 16-word extension and padding
	// that together leave an empty payload
	task automatic test_long_packets();
		tx_steady = 1'b1;
		start_random_header(8'hBF);
		push_random(60);
		push_random(2);
		push_byte(8'h00);
		push_byte(8'h10);
		push_random(64 + 4);
		push_byte(8'd5);
		send_packet();
		tx_steady = 1'b0;
	endtask

	// Receiver holds off while the sender streams short packets back to back,
	// so the result register fills and the parser stalls its byte input.
	task automatic test_backpressure();
		hold_left = HOLD_OFF_CYCLES;
		tx_steady = 1'b1;
		repeat (12) begin
			start_random_header({RTP_VERSION, 6'h00});
			push_random($urandom_range(0, 8));
			send_packet();
		end
		tx_steady = 1'b0;
	endtask

	task automatic test_random_traffic();
		int unsigned bytes_sent;
		int unsigned packets_sent;
		bytes_sent = 0;
		packets_sent = 0;
		while (bytes_sent < RANDOM_BYTES || packets_sent < RANDOM_PACKETS) begin
			// Occasional stretches with no idling on one side or the other
			tx_steady = ($urandom_range(0, 9) == 0);
			rx_steady = ($urandom_range(0, 9) == 0);
			build_random_packet();
			bytes_sent += packet_bytes.size();
			send_packet();
			packets_sent++;
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		pkt_bus.valid = 1'b0;
		pkt_bus.data_byte = 8'h00;
		pkt_bus.last_byte = 1'b0;
		clear_header_shadow();

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_short_packets();
		test_bad_version();
		test_header_extremes();
		test_padding();
		test_csrc_list();
		test_extension();
		test_long_packets();
		test_backpressure();
		test_random_traffic();

		pkt_bus.valid = 1'b0;
		pkt_bus.last_byte = 1'b0;

		// Drain: the watchdog covers a verdict that never arrives
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rtp_pkg.sv
sv/rtp_byte_if.sv
sv/rtp_result_if.sv
sv/rtp_capture.sv
sv/rtp_check.sv
sv/rtp_header_parser.sv
tb/rtp_header_parser_tb.sv
